@@ sv/mrw_pkg.sv @@
`default_nettype none

package mrw_pkg;

  // Default grid geometry.
  localparam int GRID_WIDTH_DEF  = 33;
  localparam int GRID_HEIGHT_DEF = 25;

  // Field and register widths.
  localparam int OPCODE_W   = 2;
  localparam int VIDX_W     = 10;
  localparam int HEIGHT_W   = 14;
  localparam int STORE_W    = 16;
  localparam int WAVE_W     = 8;
  localparam int PERIOD_W   = 8;
  localparam int LIMIT_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Opcodes of a request.
  localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMP_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMP_INDEX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd4;

  // Configuration reset values.
  localparam logic signed [HEIGHT_W-1:0] IMP_HEIGHT_RST = 14'sd1024;
  localparam logic [VIDX_W-1:0]          IMP_INDEX_RST  = 10'd412;
  localparam logic [PERIOD_W-1:0]        PERIOD_RST     = 8'd8;
  localparam logic [WAVE_W-1:0]          TOTAL_RST      = 8'd7;
  localparam logic [LIMIT_W-1:0]         LIMIT_RST      = 13'd4096;

  // Drain counter end value: the last centre vertex's write-back lands in the final drain cycle.
  localparam int DRAIN_LAST = 4;

  // Centre vertex descriptor handed from the sequencer to the update unit.
  typedef struct packed {
    logic valid;
    logic c_first;
    logic c_last;
    logic r_first;
    logic r_last;
    logic imp;
  } ctr_t;

  // Sequencer status towards the top level.
  typedef struct packed {
    logic busy;
    logic fin;
    logic clr_we;
  } seq_stat_t;

endpackage

`default_nettype wire

@@ sv/mrw_seq.sv @@
`default_nettype none

module mrw_seq import mrw_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int NVERT  = GRID_WIDTH * GRID_HEIGHT,
  localparam int IDX_W  = $clog2(NVERT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic                launch,
  input  logic [VIDX_W-1:0]   imp_index,
  output seq_stat_t           stat,
  output logic [IDX_W-1:0]    rd_addr,
  output logic [IDX_W-1:0]    clr_addr,
  output ctr_t                ctr,
  output logic [IDX_W-1:0]    ctr_idx
);

  localparam int CNT_W = $clog2(NVERT + GRID_WIDTH);
  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT);
  localparam int CMP_W = (IDX_W > VIDX_W) ? IDX_W : VIDX_W;

  localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(NVERT + GRID_WIDTH - 1);
  localparam logic [CNT_W-1:0] CLR_LAST   = CNT_W'(NVERT - 1);
  localparam logic [CNT_W-1:0] DRN_LAST   = CNT_W'(DRAIN_LAST);
  localparam logic [CNT_W-1:0] LEAD       = CNT_W'(GRID_WIDTH);
  localparam logic [CNT_W-1:0] NV_CNT     = CNT_W'(NVERT);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(GRID_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(GRID_HEIGHT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SWEEP,
    S_DRAIN,
    S_ONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] k_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             rpt_r;
  logic             ctr_on;

  // The centre vertex trails the read pointer by one grid row.
  assign ctr_on = (state_r == S_SWEEP) && (cnt_r >= LEAD);

  // Sequencer: clearing pass, sweep, pipeline drain and the single-state read requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      k_r     <= '0;
      col_r   <= '0;
      row_r   <= '0;
      rpt_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            cnt_r <= '0;
            k_r   <= '0;
            col_r <= '0;
            row_r <= '0;
            unique case (opcode)
              OP_START: begin
                state_r <= S_CLEAR;
                rpt_r   <= 1'b1;
              end
              OP_STEP: state_r <= S_SWEEP;
              default: state_r <= S_ONE;
            endcase
          end
        end
        S_CLEAR: begin
          if (cnt_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SWEEP: begin
          if (ctr_on) begin
            k_r <= k_r + 1'b1;
            if (col_r == COL_LAST) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
          if (cnt_r == SWEEP_LAST) begin
            state_r <= S_DRAIN;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (cnt_r == DRN_LAST) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Status towards the top level.
  always_comb begin
    stat.busy   = (state_r != S_IDLE);
    stat.clr_we = (state_r == S_CLEAR);
    stat.fin    = ((state_r == S_DRAIN) && (cnt_r == DRN_LAST)) ||
                  ((state_r == S_CLEAR) && (cnt_r == CLR_LAST) && rpt_r) ||
                  (state_r == S_ONE);
  end

  assign clr_addr = IDX_W'(cnt_r);
  assign rd_addr  = (cnt_r < NV_CNT) ? IDX_W'(cnt_r) : '0;

  // Centre vertex descriptor with its rim flags and the launch match.
  always_comb begin
    ctr.valid   = ctr_on;
    ctr.c_first = (col_r == '0);
    ctr.c_last  = (col_r == COL_LAST);
    ctr.r_first = (row_r == '0);
    ctr.r_last  = (row_r == ROW_LAST);
    ctr.imp     = launch && (CMP_W'(k_r) == CMP_W'(imp_index));
  end

  assign ctr_idx = k_r;

endmodule

`default_nettype wire

@@ sv/mrw_upd.sv @@
`default_nettype none

module mrw_upd import mrw_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int NVERT  = GRID_WIDTH * GRID_HEIGHT,
  localparam int IDX_W  = $clog2(NVERT)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctr_t                       ctr_in,
  input  logic [IDX_W-1:0]           idx_in,
  input  logic signed [STORE_W-1:0]  lead,
  input  logic signed [STORE_W-1:0]  vrd,
  input  logic signed [HEIGHT_W-1:0] imp_height,
  input  logic [LIMIT_W-1:0]         limit,
  output logic [IDX_W-1:0]           vrd_addr,
  output logic                       wr_en,
  output logic [IDX_W-1:0]           wr_addr,
  output logic signed [STORE_W-1:0]  wr_height,
  output logic signed [STORE_W-1:0]  wr_vel
);

  localparam int W    = GRID_WIDTH;
  localparam int SH_N = 2 * W + 1;

  // Descriptor delay, aligning with the height line and velocity read data.
  ctr_t             c1_r, c2_r;
  logic [IDX_W-1:0] k1_r, k2_r;

  // Snapshot line: entry 0 is the vertex one row ahead, entry W the centre.
  logic signed [STORE_W-1:0] sh_r [SH_N];

  // Stage A: masked neighbour pair sums.
  logic signed [STORE_W-1:0] nl, nr, nu, nd, h_a;
  logic                      a_valid_r, a_rim_r;
  logic [IDX_W-1:0]          a_k_r;
  logic signed [STORE_W:0]   a_s1_r, a_s2_r;
  logic signed [STORE_W-1:0] a_h_r, a_v_r;

  // Stage B: average truncated toward zero, and velocity minus height.
  logic signed [STORE_W+1:0] sum_b, rnd_b;
  logic                      b_valid_r, b_rim_r;
  logic [IDX_W-1:0]          b_k_r;
  logic signed [STORE_W-1:0] b_avg_r, b_h_r;
  logic signed [STORE_W:0]   b_d_r;

  // Stage C: new velocity, wrapped to the store width.
  logic signed [STORE_W+1:0] t_c;
  logic                      c_valid_r, c_rim_r;
  logic [IDX_W-1:0]          c_k_r;
  logic signed [STORE_W-1:0] c_v_r, c_h_r;

  // Stage D: height update, clamp and rim pinning.
  logic signed [STORE_W:0]   nh, lim, nlim, nh_cl;

  // Descriptor delay registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
    end else begin
      c1_r <= ctr_in;
      c2_r <= c1_r;
    end
    k1_r <= idx_in;
    k2_r <= k1_r;
  end

  assign vrd_addr = k1_r;

  // Height line shifts every cycle; only aligned taps are ever used.
  always_ff @(posedge clk) begin
    sh_r[0] <= lead;
    for (int i = 1; i < SH_N; i++) begin
      sh_r[i] <= sh_r[i-1];
    end
  end

  // Neighbours off the grid count as zero; the launch vertex takes the impulse.
  always_comb begin
    nl  = c2_r.c_first ? '0 : sh_r[W+1];
    nr  = c2_r.c_last  ? '0 : sh_r[W-1];
    nu  = c2_r.r_first ? '0 : sh_r[2*W];
    nd  = c2_r.r_last  ? '0 : sh_r[0];
    h_a = c2_r.imp ? {{(STORE_W-HEIGHT_W){imp_height[HEIGHT_W-1]}}, imp_height} : sh_r[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= c2_r.valid;
    end
    a_rim_r <= c2_r.c_first | c2_r.c_last | c2_r.r_first | c2_r.r_last;
    a_k_r   <= k2_r;
    a_s1_r  <= {nl[STORE_W-1], nl} + {nr[STORE_W-1], nr};
    a_s2_r  <= {nu[STORE_W-1], nu} + {nd[STORE_W-1], nd};
    a_h_r   <= h_a;
    a_v_r   <= vrd;
  end

  // A negative sum is biased by three before the shift to round toward zero.
  always_comb begin
    sum_b = {a_s1_r[STORE_W], a_s1_r} + {a_s2_r[STORE_W], a_s2_r};
    rnd_b = sum_b + (sum_b[STORE_W+1] ? (STORE_W+2)'(3) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_rim_r <= a_rim_r;
    b_k_r   <= a_k_r;
    b_avg_r <= rnd_b[STORE_W+1:2];
    b_d_r   <= {a_v_r[STORE_W-1], a_v_r} - {a_h_r[STORE_W-1], a_h_r};
    b_h_r   <= a_h_r;
  end

  assign t_c = {{2{b_avg_r[STORE_W-1]}}, b_avg_r} + {b_d_r[STORE_W], b_d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
    c_rim_r <= b_rim_r;
    c_k_r   <= b_k_r;
    c_v_r   <= t_c[STORE_W-1:0];
    c_h_r   <= b_h_r;
  end

  // Clamp to the symmetric limit, then pin the rim to zero.
  always_comb begin
    nh   = {c_h_r[STORE_W-1], c_h_r} + {c_v_r[STORE_W-1], c_v_r};
    lim  = {{(STORE_W+1-LIMIT_W){1'b0}}, limit};
    nlim = -lim;
    priority if (c_rim_r) begin
      nh_cl = '0;
    end else if (nh > lim) begin
      nh_cl = lim;
    end else if (nh < nlim) begin
      nh_cl = nlim;
    end else begin
      nh_cl = nh;
    end
  end

  assign wr_en     = c_valid_r;
  assign wr_addr   = c_k_r;
  assign wr_height = nh_cl[STORE_W-1:0];
  assign wr_vel    = c_v_r;

endmodule

`default_nettype wire

@@ sv/mesh_ripple_wave_step_top.sv @@
`default_nettype none

// Ripple simulation on a GRID_WIDTH x GRID_HEIGHT vertex grid (825 vertices by default).
// Requests: in_opcode and in_vertex_index are taken when start is high and busy is low.
// Every request gives one result, shown on out_height, out_done_res and out_waves_left
// for the single cycle in which out_valid is high; the receiver cannot stall it.
// Configuration: cfg_index and cfg_data are written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high, and writes are meant for idle periods only.
// What each request does between the accepting edge and the result cycle:
//   read and the unused opcode: a single sequencer state, then the result;
//   start: a clearing pass over the NVERT vertices, one clearing write per vertex;
//   step: a sweep over the grid, one vertex update per cycle through the shared update
//   pipeline, set by the single write port of each store, then a pipeline drain.
// busy stays high from acceptance until the result cycle, so one request is in
// flight at a time. After reset, busy is high for a clearing pass over every vertex
// that zeroes the height and velocity stores; configuration writes are still taken
// during it.
module mesh_ripple_wave_step_top import mrw_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [OPCODE_W-1:0]        in_opcode,
  input  logic [VIDX_W-1:0]          in_vertex_index,
  output logic                       out_valid,
  output logic signed [HEIGHT_W-1:0] out_height,
  output logic                       out_done_res,
  output logic [WAVE_W-1:0]          out_waves_left,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int NVERT = GRID_WIDTH * GRID_HEIGHT;
  localparam int IDX_W = $clog2(NVERT);
  localparam int CMP_W = (IDX_W > VIDX_W) ? IDX_W : VIDX_W;

  // Configuration registers.
  logic signed [HEIGHT_W-1:0] imp_height_r;
  logic [VIDX_W-1:0]          imp_index_r;
  logic [PERIOD_W-1:0]        period_r;
  logic [WAVE_W-1:0]          total_r;
  logic [LIMIT_W-1:0]         limit_r;

  // Wave control.
  logic [PERIOD_W-1:0] timer_r;
  logic [WAVE_W-1:0]   waves_r;
  logic                launch_r;

  // Request bookkeeping.
  logic                acc;
  logic [OPCODE_W-1:0] op_r;
  logic                inrange_r;
  logic [CMP_W-1:0]    vi_ext;
  logic                vi_ok;

  // Stores.
  logic signed [STORE_W-1:0] hmem [NVERT];
  logic signed [STORE_W-1:0] vmem [NVERT];
  logic signed [STORE_W-1:0] hrd_r, vrd_r;
  logic [IDX_W-1:0]          h_ra, h_wa, v_wa;
  logic signed [STORE_W-1:0] h_wd, v_wd;
  logic                      h_we;

  // Sub-module connections.
  seq_stat_t                 stat;
  logic [IDX_W-1:0]          seq_rd_addr, clr_addr, ctr_idx;
  ctr_t                      ctr;
  logic [IDX_W-1:0]          vrd_addr, upd_wa;
  logic                      upd_we;
  logic signed [STORE_W-1:0] upd_h, upd_v;

  // Result registers.
  logic                       out_valid_r;
  logic signed [HEIGHT_W-1:0] out_height_r;
  logic                       out_done_r;
  logic [WAVE_W-1:0]          out_waves_r;

  assign busy      = stat.busy;
  assign acc       = start & ~stat.busy;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imp_height_r <= IMP_HEIGHT_RST;
      imp_index_r  <= IMP_INDEX_RST;
      period_r     <= PERIOD_RST;
      total_r      <= TOTAL_RST;
      limit_r      <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMP_HEIGHT: imp_height_r <= cfg_data[HEIGHT_W-1:0];
        CFG_IMP_INDEX:  imp_index_r  <= cfg_data[VIDX_W-1:0];
        CFG_PERIOD:     period_r     <= cfg_data[PERIOD_W-1:0];
        CFG_TOTAL:      total_r      <= cfg_data[WAVE_W-1:0];
        CFG_LIMIT:      limit_r      <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Wave timer and counter, updated when a start or step request is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= '0;
      waves_r  <= '0;
      launch_r <= 1'b0;
    end else if (acc) begin
      if (in_opcode == OP_START) begin
        waves_r  <= total_r;
        timer_r  <= '0;
        launch_r <= 1'b0;
      end else if (in_opcode == OP_STEP) begin
        if ((timer_r == '0) && (waves_r != '0)) begin
          launch_r <= 1'b1;
          timer_r  <= period_r;
          waves_r  <= waves_r - 1'b1;
        end else begin
          launch_r <= 1'b0;
          if (timer_r != '0) begin
            timer_r <= timer_r - 1'b1;
          end
        end
      end
    end
  end

  // A read outside the grid returns zero.
  assign vi_ext = CMP_W'(in_vertex_index);
  assign vi_ok  = (vi_ext < CMP_W'(NVERT));

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r      <= in_opcode;
      inrange_r <= vi_ok;
    end
  end

  mrw_seq #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .opcode    (in_opcode),
    .launch    (launch_r),
    .imp_index (imp_index_r),
    .stat      (stat),
    .rd_addr   (seq_rd_addr),
    .clr_addr  (clr_addr),
    .ctr       (ctr),
    .ctr_idx   (ctr_idx)
  );

  mrw_upd #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_upd (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctr_in     (ctr),
    .idx_in     (ctr_idx),
    .lead       (hrd_r),
    .vrd        (vrd_r),
    .imp_height (imp_height_r),
    .limit      (limit_r),
    .vrd_addr   (vrd_addr),
    .wr_en      (upd_we),
    .wr_addr    (upd_wa),
    .wr_height  (upd_h),
    .wr_vel     (upd_v)
  );

  // Store ports: the clearing pass and the sweep write-back never overlap.
  always_comb begin
    h_ra = (acc && (in_opcode == OP_READ) && vi_ok) ? IDX_W'(vi_ext) : seq_rd_addr;
    h_we = stat.clr_we | upd_we;
    h_wa = stat.clr_we ? clr_addr : upd_wa;
    v_wa = h_wa;
    h_wd = stat.clr_we ? '0 : upd_h;
    v_wd = stat.clr_we ? '0 : upd_v;
  end

  // Height store.
  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    hrd_r <= hmem[h_ra];
  end

  // Velocity store.
  always_ff @(posedge clk) begin
    if (h_we) begin
      vmem[v_wa] <= v_wd;
    end
    vrd_r <= vmem[vrd_addr];
  end

  // Result registers, loaded in the last cycle of each request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stat.fin;
    end
    if (stat.fin) begin
      out_height_r <= ((op_r == OP_READ) && inrange_r) ? hrd_r[HEIGHT_W-1:0] : '0;
      out_done_r   <= (waves_r == '0);
      out_waves_r  <= waves_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_height     = out_height_r;
  assign out_done_res   = out_done_r;
  assign out_waves_left = out_waves_r;

`ifndef SYNTHESIS
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy) else $error("busy did not rise after an accepted request");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");

  a_res_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe lasted more than one cycle");

  a_done_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_done_res == (out_waves_left == '0)))
    else $error("done flag disagrees with waves left");
`endif

endmodule

`default_nettype wire
